// ----- hw/rtl/sdtg_pkg.sv -----
package sdtg_pkg;

  // Default sizing of the sine table and the phase accumulator
  localparam int unsigned SINE_DEPTH_DEFAULT = 1024;
  localparam int unsigned PHASE_BITS_DEFAULT = 32;

  // Field and datapath widths
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned FREQ_W   = 11;
  localparam int unsigned FS_W     = FREQ_W + STEP_W;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned TABLE_W  = 31;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(89478);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_KEY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KEY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;

  // Keypad frequencies in hertz
  localparam logic [FREQ_W-1:0] FREQ_NONE  = 11'd0;
  localparam logic [FREQ_W-1:0] FREQ_ROW_1 = 11'd697;
  localparam logic [FREQ_W-1:0] FREQ_ROW_2 = 11'd770;
  localparam logic [FREQ_W-1:0] FREQ_ROW_3 = 11'd852;
  localparam logic [FREQ_W-1:0] FREQ_ROW_4 = 11'd941;
  localparam logic [FREQ_W-1:0] FREQ_COL_1 = 11'd1209;
  localparam logic [FREQ_W-1:0] FREQ_COL_2 = 11'd1336;
  localparam logic [FREQ_W-1:0] FREQ_COL_3 = 11'd1477;
  localparam logic [FREQ_W-1:0] FREQ_COL_4 = 11'd1633;

  // One of the four tones worked per sample, in issue order
  typedef enum logic [1:0] {
    TONE_L_ROW = 2'd0,
    TONE_L_COL = 2'd1,
    TONE_R_ROW = 2'd2,
    TONE_R_COL = 2'd3
  } tone_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  start;      // request accepted: take restart into the counter
    logic  issue_en;   // start a tone down the phase pipeline
    tone_e issue_tone;
    logic  acc_en;     // table value of a tone is ready to add
    tone_e acc_tone;
    logic  load_out;   // move sums to the output register, advance counter
  } dp_cmd_t;

  // Map a key to its row tone; unknown keys give silence
  function automatic logic [FREQ_W-1:0] key_row_freq(input logic [KEY_W-1:0] key);
    logic [FREQ_W-1:0] f;
    case (key)
      "1", "2", "3", "A": f = FREQ_ROW_1;
      "4", "5", "6", "B": f = FREQ_ROW_2;
      "7", "8", "9", "C": f = FREQ_ROW_3;
      "*", "0", "#", "D": f = FREQ_ROW_4;
      default:            f = FREQ_NONE;
    endcase
    return f;
  endfunction

  // Map a key to its column tone; unknown keys give silence
  function automatic logic [FREQ_W-1:0] key_col_freq(input logic [KEY_W-1:0] key);
    logic [FREQ_W-1:0] f;
    case (key)
      "1", "4", "7", "*": f = FREQ_COL_1;
      "2", "5", "8", "0": f = FREQ_COL_2;
      "3", "6", "9", "#": f = FREQ_COL_3;
      "A", "B", "C", "D": f = FREQ_COL_4;
      default:            f = FREQ_NONE;
    endcase
    return f;
  endfunction

endpackage

// ----- hw/rtl/sdtg_ctrl.sv -----
module sdtg_ctrl
  import sdtg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  output logic    m_tvalid_o,
  input  logic    m_tready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;

  // Sequence the steps: first half issues tones, second half adds them up
  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    cmd_o            = '0;
    cmd_o.issue_tone = tone_e'(step_q[1:0]);
    cmd_o.acc_tone   = tone_e'(step_q[1:0]);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          step_d      = '0;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue_en = !step_q[2];
        cmd_o.acc_en   = step_q[2];
        step_d         = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q && !m_tready_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_tready_i))
    else $error("output register overwritten while a result is pending");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (step_q == 3'd0))
    else $error("accepted request did not start at the first step");

  a_run_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && (step_q == 3'd7) |=> (state_q == ST_DONE))
    else $error("last step did not lead to result hand-off");

endmodule

// ----- hw/rtl/sdtg_datapath.sv -----
module sdtg_datapath
  import sdtg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT,
  parameter int unsigned PHASE_BITS       = PHASE_BITS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  logic                       restart_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [STEP_W-1:0]          cfg_data_i,
  output logic signed [SAMPLE_W-1:0] left_sample_o,
  output logic signed [SAMPLE_W-1:0] right_sample_o
);

  localparam int unsigned IDX_W     = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned IDX_PW    = PHASE_BITS + IDX_W;
  localparam int unsigned PROD_W    = COUNT_W + FS_W;
  localparam logic [63:0] Q30_ONE   = 64'd1073741824;
  localparam logic [63:0] HALF_PI   = 64'd1686629713;

  // Quarter-wave polynomial sine, evaluated at elaboration for each entry
  function automatic logic signed [TABLE_W-1:0] sine_entry(input logic [63:0] k);
    logic [63:0] q, r, x, x2, t, s, mag;
    q = (64'd4 * k) / 64'(SINE_TABLE_DEPTH);
    r = (64'd4 * k) % 64'(SINE_TABLE_DEPTH);
    if (q[0]) begin
      r = 64'(SINE_TABLE_DEPTH) - r;
    end
    x  = (r * HALF_PI + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s   = (x * t) >> 30;
    mag = (s + 64'd1) >> 1;
    return (q >= 64'd2) ? -$signed(TABLE_W'(mag)) : $signed(TABLE_W'(mag));
  endfunction

  logic [KEY_W-1:0]          left_key_q, right_key_q;
  logic [STEP_W-1:0]         step_q;
  logic [COUNT_W-1:0]        n_q;
  logic [FREQ_W-1:0]         freq;
  logic [FS_W-1:0]           fs_q;
  logic [PROD_W-1:0]         prod;
  logic [PHASE_BITS-1:0]     phase_q;
  logic [IDX_PW-1:0]         idx_prod;
  logic [IDX_W-1:0]          idx_q;
  logic signed [TABLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic signed [TABLE_W-1:0] rom_q;
  logic signed [SAMPLE_W-1:0] tone_ext;
  logic signed [SAMPLE_W-1:0] left_acc_q, right_acc_q;
  logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;

  // Constant sine table
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(64'(k));
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_key_q  <= '0;
      right_key_q <= '0;
      step_q      <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LEFT_KEY:  left_key_q  <= cfg_data_i[KEY_W-1:0];
        REG_RIGHT_KEY: right_key_q <= cfg_data_i[KEY_W-1:0];
        REG_STEP:      step_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample counter: clear on restart, advance once the result is out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.start && restart_i) begin
      n_q <= '0;
    end else if (cmd_i.load_out) begin
      n_q <= n_q + COUNT_W'(1);
    end
  end

  // Select the frequency of the issued tone
  always_comb begin
    unique case (cmd_i.issue_tone)
      TONE_L_ROW: freq = key_row_freq(left_key_q);
      TONE_L_COL: freq = key_col_freq(left_key_q);
      TONE_R_ROW: freq = key_row_freq(right_key_q);
      TONE_R_COL: freq = key_col_freq(right_key_q);
      default:    freq = FREQ_NONE;
    endcase
  end

  assign prod     = PROD_W'(n_q) * PROD_W'(fs_q);
  assign idx_prod = IDX_PW'(phase_q) * IDX_PW'(SINE_TABLE_DEPTH);

  // Phase pipeline: step per sample, phase, table index, table read
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_en) begin
      fs_q <= FS_W'(freq) * FS_W'(step_q);
    end
    phase_q <= prod[PHASE_BITS-1:0];
    idx_q   <= idx_prod[IDX_PW-1:PHASE_BITS];
    rom_q   <= sine_rom[idx_q];
  end

  assign tone_ext = {rom_q[TABLE_W-1], rom_q};

  // Add the two tones of each channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      unique case (cmd_i.acc_tone)
        TONE_L_ROW: left_acc_q  <= tone_ext;
        TONE_L_COL: left_acc_q  <= left_acc_q + tone_ext;
        TONE_R_ROW: right_acc_q <= tone_ext;
        TONE_R_COL: right_acc_q <= right_acc_q + tone_ext;
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      left_out_q  <= left_acc_q;
      right_out_q <= right_acc_q;
    end
  end

  assign left_sample_o  = left_out_q;
  assign right_sample_o = right_out_q;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && restart_i |=> (n_q == '0))
    else $error("restart did not clear the sample counter");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && !cmd_i.start |=> (n_q == $past(n_q) + COUNT_W'(1)))
    else $error("sample counter did not advance after a result");

endmodule

// ----- hw/rtl/stereo_dtmf_tone_generator.sv -----
// Stereo DTMF tone generator.
//
// Each request on the slave stream is one sample tick; it yields one result
// on the master stream holding the left and right samples. Each channel sums
// the row and column tones of its configured key; unknown keys are silent.
// The configuration channel (index, data) writes left key, right key and the
// phase step per hertz; write it only while no request is in flight.
//
// Flow: a request is taken in the idle cycle, the four tones then go one
// per cycle through a shared multiply / table pipeline and are summed, and
// the sums are moved to the output register, which drives m_axis_tvalid.
// The next request is taken only after that hand-off, once the block is
// idle again; it takes no new request while one is still being worked.
// A result waits in the output register while the receiver stalls; the
// next request is still taken and worked, and its hand-off waits until the
// register is free. Reset clears the sample counter, the keys to zero and
// the step to 89478, and drops any pending result.
module stereo_dtmf_tone_generator
  import sdtg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT,
  parameter int unsigned PHASE_BITS       = PHASE_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] restart, [7:1] zero
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // [31:0] left_sample, [63:32] right_sample
  // Configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [STEP_W-1:0]    cfg_data_i
);

  dp_cmd_t                    cmd;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  assign cfg_ready_o = 1'b1;

  sdtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  sdtg_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .restart_i      (s_axis_tdata[0]),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .left_sample_o  (left_sample),
    .right_sample_o (right_sample)
  );

  assign m_axis_tdata = {right_sample, left_sample};

endmodule
